// ===== hdl/csb_pkg.sv =====
// Shared constants, types and helper functions for the cardinal spline to Bezier converter.
// Used by every module in the hdl folder; depends on nothing else.
`default_nettype none

package csb_pkg;

  // Field widths.
  localparam int KW = 16;   // knot coordinate
  localparam int TW = 16;   // tension, unsigned Q4.12
  localparam int OW = 18;   // output point coordinate

  // Internal datapath widths.
  localparam int DW = KW + 3;            // weighted knot differences
  localparam int MW = DW + TW + 1;       // difference times signed tension
  localparam int PW = MW + 2;            // raw Q12 coefficient sums
  localparam int CW = 26;                // rounded cubic coefficients
  localparam int BW = CW + 2;            // Bezier points before saturation
  localparam int EW = KW + 1;            // knot difference a1 - a2

  // Fixed point.
  localparam int Q_FRAC = 12;
  localparam logic [PW-1:0] HALF_UP   = PW'(2048);
  localparam logic [PW-1:0] HALF_DOWN = PW'(2047);

  // Exact division by three: q = (m * DIV3_RECIP) >> DIV3_SHIFT for m below 2**CW.
  localparam int DIV3_SHIFT = 27;
  localparam logic [CW-1:0] DIV3_RECIP = CW'(44739243);
  localparam int QW = 2 * CW - DIV3_SHIFT;

  // Window.
  localparam int WIN_DEPTH = 3;
  localparam logic [1:0] FILL_FULL = 2'd3;

  // Index of the Bezier point being sent.
  localparam logic [1:0] IDX_B0 = 2'd0;
  localparam logic [1:0] IDX_B1 = 2'd1;
  localparam logic [1:0] IDX_B3 = 2'd3;

  // Configuration port.
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  localparam logic [ADDR_W-3:0] REG_TENSION = '0;
  localparam logic [TW-1:0] TENSION_RESET = 16'd1638;

  // Four knots of one coordinate.
  typedef struct packed {
    logic signed [KW-1:0] k0;
    logic signed [KW-1:0] k1;
    logic signed [KW-1:0] k2;
    logic signed [KW-1:0] k3;
  } knot_set_t;

  // Stage load enables for the coordinate datapath.
  typedef struct packed {
    logic ld2;
    logic ld3;
    logic ld4;
    logic ld5;
  } pipe_ld_t;

  // Divide a Q12 value by 4096, rounding to nearest with halves away from zero.
  function automatic logic signed [CW-1:0] round_q12(input logic signed [PW-1:0] s);
    logic signed [PW-1:0] adj;
    adj = s + $signed(s[PW-1] ? HALF_DOWN : HALF_UP);
    return adj[CW+Q_FRAC-1:Q_FRAC];
  endfunction

  // Clamp a point to the output range.
  function automatic logic signed [OW-1:0] sat_pt(input logic signed [BW-1:0] v);
    logic fits;
    fits = (v[BW-1:OW-1] == '0) || (v[BW-1:OW-1] == '1);
    if (fits) begin
      return v[OW-1:0];
    end
    return v[BW-1] ? {1'b1, {(OW-1){1'b0}}} : {1'b0, {(OW-1){1'b1}}};
  endfunction

endpackage

`default_nettype wire

// ===== hdl/cardinal_spline_to_bezier.sv =====
// Top level of the cardinal spline to cubic Bezier converter: configuration port,
// pipeline control, and the window, coordinate and output modules. Depends on csb_pkg.
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_stall    knot_x, knot_y, start_curve
//   out      output     out_valid / out_stall  point_x, point_y, last_of_run
//   config   input      APB psel/penable       tension at byte address 0
//
// A knot that completes a window yields three points (four on a curve's first segment)
// after passing the segment register and stages 2 to 5; other knots yield nothing.
// Sustained rate is set by the single output channel, which sends one point per transaction.
// The stage pipeline holds up to five segments, so knots keep entering while points drain.
// Reset is synchronous; out_stall holds the pipeline back stage by stage up to in_stall.
`default_nettype none

module cardinal_spline_to_bezier import csb_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic signed [KW-1:0] knot_x,
  input  wire logic signed [KW-1:0] knot_y,
  input  wire logic                 start_curve,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic signed [OW-1:0]      point_x,
  output logic signed [OW-1:0]      point_y,
  output logic                      last_of_run,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [ADDR_W-1:0]    paddr,
  input  wire logic [DATA_W-1:0]    pwdata,
  output logic [DATA_W-1:0]         prdata,
  output logic                      pready
);

  logic [TW-1:0] tension;
  logic          reg_hit;

  // Configuration register.
  assign pready  = 1'b1;
  assign reg_hit = (paddr[ADDR_W-1:2] == REG_TENSION);
  assign prdata  = reg_hit ? DATA_W'(tension) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      tension <= TENSION_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      tension <= pwdata[TW-1:0];
    end
  end

  // Stage valids and the first-segment flag that travel with each segment.
  logic      v1, v2, v3, v4;
  logic      f2, f3, f4;
  logic      s1_first;
  logic      free5;
  logic      rdy2, rdy3, rdy4;
  pipe_ld_t  ld;
  logic      accept;
  knot_set_t s1_x, s1_y;
  logic [1:0] sel;

  always_comb begin
    rdy4   = !v4 || free5;
    rdy3   = !v3 || rdy4;
    rdy2   = !v2 || rdy3;
    ld.ld5 = v4 && free5;
    ld.ld4 = v3 && rdy4;
    ld.ld3 = v2 && rdy3;
    ld.ld2 = v1 && rdy2;
    in_stall = v1 && !rdy2;
    accept   = in_valid && !in_stall;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v2 <= ld.ld2 || (v2 && !ld.ld3);
      v3 <= ld.ld3 || (v3 && !ld.ld4);
      v4 <= ld.ld4 || (v4 && !ld.ld5);
    end
  end

  always_ff @(posedge clk) begin
    if (ld.ld2) begin
      f2 <= s1_first;
    end
    if (ld.ld3) begin
      f3 <= f2;
    end
    if (ld.ld4) begin
      f4 <= f3;
    end
  end

  csb_window u_window (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .knot_x      (knot_x),
    .knot_y      (knot_y),
    .start_curve (start_curve),
    .ld2         (ld.ld2),
    .v1          (v1),
    .s1_x        (s1_x),
    .s1_y        (s1_y),
    .s1_first    (s1_first)
  );

  csb_axis u_axis_x (
    .clk     (clk),
    .ld      (ld),
    .tension (tension),
    .knots   (s1_x),
    .sel     (sel),
    .point   (point_x)
  );

  csb_axis u_axis_y (
    .clk     (clk),
    .ld      (ld),
    .tension (tension),
    .knots   (s1_y),
    .sel     (sel),
    .point   (point_y)
  );

  csb_emit u_emit (
    .clk         (clk),
    .rst         (rst),
    .ld5         (ld.ld5),
    .first4      (f4),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .last_of_run (last_of_run),
    .sel         (sel),
    .free        (free5)
  );

endmodule

`default_nettype wire

// ===== hdl/csb_window.sv =====
// Knot window: keeps the last three knots of a curve and launches full four-knot segments.
// Depends on csb_pkg.
`default_nettype none

module csb_window import csb_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 accept,
  input  wire logic signed [KW-1:0] knot_x,
  input  wire logic signed [KW-1:0] knot_y,
  input  wire logic                 start_curve,
  input  wire logic                 ld2,
  output logic                      v1,
  output knot_set_t                 s1_x,
  output knot_set_t                 s1_y,
  output logic                      s1_first
);

  logic [1:0] fill;
  logic       first_pending;
  logic [1:0] fill_eff;
  logic       first_eff;
  logic       full;
  logic signed [KW-1:0] wx [WIN_DEPTH];
  logic signed [KW-1:0] wy [WIN_DEPTH];

  // A start flag restarts the curve before this knot is taken.
  always_comb begin
    fill_eff  = start_curve ? 2'd0 : fill;
    first_eff = start_curve | first_pending;
    full      = (fill_eff == FILL_FULL);
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      fill          <= '0;
      first_pending <= 1'b1;
      v1            <= 1'b0;
    end else begin
      if (accept) begin
        if (!full) begin
          fill          <= fill_eff + 2'd1;
          first_pending <= first_eff;
        end else begin
          fill          <= fill_eff;
          first_pending <= 1'b0;
        end
      end
      v1 <= (accept && full) || (v1 && !ld2);
    end
  end

  // Window contents and the segment register.
  always_ff @(posedge clk) begin
    if (accept) begin
      if (!full) begin
        wx[fill_eff] <= knot_x;
        wy[fill_eff] <= knot_y;
      end else begin
        s1_x     <= '{k0: wx[0], k1: wx[1], k2: wx[2], k3: knot_x};
        s1_y     <= '{k0: wy[0], k1: wy[1], k2: wy[2], k3: knot_y};
        s1_first <= first_eff;
        wx[0]    <= wx[1];
        wx[1]    <= wx[2];
        wx[2]    <= knot_x;
        wy[0]    <= wy[1];
        wy[1]    <= wy[2];
        wy[2]    <= knot_y;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/csb_axis.sv =====
// One coordinate of the segment datapath: tension products, cubic coefficients,
// thirds and saturated Bezier points. Depends on csb_pkg.
`default_nettype none

module csb_axis import csb_pkg::*; (
  input  wire logic                 clk,
  input  wire pipe_ld_t             ld,
  input  wire logic [TW-1:0]        tension,
  input  wire knot_set_t            knots,
  input  wire logic [1:0]           sel,
  output logic signed [OW-1:0]      point
);

  // Stage 2: products with the tension.
  logic signed [DW-1:0] a0, a1, a2, a3;
  logic signed [DW-1:0] d3, d2, d1;
  logic signed [TW:0]   t_s;
  logic signed [MW-1:0] m3, m2, m1;
  logic signed [PW-1:0] p3, p2, p1;
  logic signed [EW-1:0] e2r;
  logic signed [KW-1:0] c0_2;

  always_comb begin
    a0  = DW'(knots.k0);
    a1  = DW'(knots.k1);
    a2  = DW'(knots.k2);
    a3  = DW'(knots.k3);
    t_s = $signed({1'b0, tension});
    d3  = a3 + a2 - a1 - a0;
    d2  = (a0 <<< 1) + a1 - (a2 <<< 1) - a3;
    d1  = a2 - a0;
    m3  = d3 * t_s;
    m2  = d2 * t_s;
    m1  = d1 * t_s;
  end

  always_ff @(posedge clk) begin
    if (ld.ld2) begin
      p3   <= PW'(m3);
      p2   <= PW'(m2);
      p1   <= PW'(m1);
      e2r  <= EW'(knots.k1) - EW'(knots.k2);
      c0_2 <= knots.k1;
    end
  end

  // Stage 3: add the fixed matrix terms and round to integer coefficients.
  logic signed [PW-1:0] e_w, raw3, raw2;
  logic signed [CW-1:0] c1_3, c2_3, c3_3;
  logic signed [KW-1:0] c0_3;

  always_comb begin
    e_w  = PW'(e2r);
    raw3 = p3 + (e_w <<< (Q_FRAC + 1));
    raw2 = p2 - (e_w <<< (Q_FRAC + 1)) - (e_w <<< Q_FRAC);
  end

  always_ff @(posedge clk) begin
    if (ld.ld3) begin
      c3_3 <= round_q12(raw3);
      c2_3 <= round_q12(raw2);
      c1_3 <= round_q12(p1);
      c0_3 <= c0_2;
    end
  end

  // Stage 4: magnitudes of the rounded thirds, and the end point.
  logic signed [CW-1:0] s12;
  logic [CW-1:0]        mag1, mag12;
  logic [2*CW-1:0]      prod1, prod12;
  logic [QW-1:0]        q1_4, q12_4;
  logic                 neg1_4, neg12_4;
  logic signed [KW-1:0] c0_4;
  logic signed [BW-1:0] b3_4;

  always_comb begin
    s12    = c1_3 + c2_3;
    mag1   = (c1_3[CW-1] ? -c1_3 : c1_3) + CW'(1);
    mag12  = (s12[CW-1] ? -s12 : s12) + CW'(1);
    prod1  = mag1 * DIV3_RECIP;
    prod12 = mag12 * DIV3_RECIP;
  end

  always_ff @(posedge clk) begin
    if (ld.ld4) begin
      q1_4    <= prod1[2*CW-1:DIV3_SHIFT];
      q12_4   <= prod12[2*CW-1:DIV3_SHIFT];
      neg1_4  <= c1_3[CW-1];
      neg12_4 <= s12[CW-1];
      c0_4    <= c0_3;
      b3_4    <= BW'(c0_3) + BW'(c1_3) + BW'(c2_3) + BW'(c3_3);
    end
  end

  // Stage 5: inner control points; all four points saturated and held for the output.
  logic signed [QW:0]   q1s, q12s;
  logic signed [BW-1:0] b0, b1, b2;
  logic signed [OW-1:0] pts [4];

  always_comb begin
    q1s  = neg1_4 ? -$signed({1'b0, q1_4}) : $signed({1'b0, q1_4});
    q12s = neg12_4 ? -$signed({1'b0, q12_4}) : $signed({1'b0, q12_4});
    b0   = BW'(c0_4);
    b1   = b0 + BW'(q1s);
    b2   = b1 + BW'(q12s);
  end

  always_ff @(posedge clk) begin
    if (ld.ld5) begin
      pts[0] <= sat_pt(b0);
      pts[1] <= sat_pt(b1);
      pts[2] <= sat_pt(b2);
      pts[3] <= sat_pt(b3_4);
    end
  end

  assign point = pts[sel];

endmodule

`default_nettype wire

// ===== hdl/csb_emit.sv =====
// Output sequencer: steps through the Bezier points of one segment, one transaction each.
// Depends on csb_pkg.
`default_nettype none

module csb_emit import csb_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       ld5,
  input  wire logic       first4,
  input  wire logic       out_stall,
  output logic            out_valid,
  output logic            last_of_run,
  output logic [1:0]      sel,
  output logic            free
);

  logic       done;
  logic [1:0] sel_next;
  logic       valid_next;

  // The segment leaves once its end point is taken.
  always_comb begin
    last_of_run = (sel == IDX_B3);
    done        = out_valid && !out_stall && last_of_run;
    free        = !out_valid || done;
    sel_next    = sel;
    valid_next  = out_valid && !done;
    if (ld5) begin
      sel_next   = first4 ? IDX_B0 : IDX_B1;
      valid_next = 1'b1;
    end else if (out_valid && !out_stall && !last_of_run) begin
      sel_next = sel + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sel       <= IDX_B1;
    end else begin
      out_valid <= valid_next;
      sel       <= sel_next;
    end
  end

endmodule

`default_nettype wire

// ===== tb/cardinal_spline_to_bezier_tb.sv =====
`timescale 1ns / 1ps
// Testbench for the cardinal spline to Bezier converter: drives knots, programs the tension
// register over APB, and checks every Bezier point against its own fixed point model.
// Depends on csb_pkg and the cardinal_spline_to_bezier top level.

module cardinal_spline_to_bezier_tb import csb_pkg::*; ();

  localparam int  CYCLE_LIMIT  = 800000;
  localparam int  SETTLE_TICKS = 8;
  localparam int  PHASES       = 8;
  localparam int  PHASE_KNOTS  = 48;
  localparam int  NUM_DIRECTED = 23;
  localparam logic [ADDR_W-1:0] TENSION_ADDR = {REG_TENSION, 2'b00};

  // Q12 constants and output range for the model.
  localparam longint HALF_Q12  = 2048;
  localparam longint ONE_Q12   = 4096;
  localparam longint TWO_Q12   = 8192;
  localparam longint THREE_Q12 = 12288;
  localparam longint PT_MAX    = 131071;
  localparam longint PT_MIN    = -131072;
  localparam int     WIN_FULL  = 3;

  typedef struct packed {
    logic signed [OW-1:0] x;
    logic signed [OW-1:0] y;
    logic                 run_end;
  } bez_point_t;

  // One directed knot; ex/ey give the final point of the run where typed is set.
  typedef struct packed {
    logic                 cfg;
    logic [TW-1:0]        tension;
    logic signed [KW-1:0] x;
    logic signed [KW-1:0] y;
    logic                 sc;
    logic                 typed;
    logic signed [OW-1:0] ex;
    logic signed [OW-1:0] ey;
  } knot_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic signed [KW-1:0] knot_x = '0;
  logic signed [KW-1:0] knot_y = '0;
  logic                 start_curve = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic signed [OW-1:0] point_x;
  logic signed [OW-1:0] point_y;
  logic                 last_of_run;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [ADDR_W-1:0]    paddr = '0;
  logic [DATA_W-1:0]    pwdata = '0;
  logic [DATA_W-1:0]    prdata;
  logic                 pready;

  // Model state: tension and the three-knot window per coordinate.
  logic [TW-1:0]        cur_tension = TENSION_RESET;
  logic signed [KW-1:0] win_x [WIN_DEPTH];
  logic signed [KW-1:0] win_y [WIN_DEPTH];
  int                   fill = 0;
  bit                   first_pending = 1'b1;

  bez_point_t bezier_points_due[$];
  int         error_count = 0;
  int         cycle_count = 0;
  int         stall_left = 0;
  bit         no_idle = 1'b0;

  knot_row_t directed_rows [NUM_DIRECTED] = '{
    //  cfg   tension    x          y          sc    typed ex          ey
    '{1'b0, 16'd0,     16'sd0,    16'sd0,    1'b0, 1'b0, 18'sd0,     18'sd0},
    '{1'b0, 16'd0,     16'sd0,    16'sd0,    1'b0, 1'b0, 18'sd0,     18'sd0},
    '{1'b0, 16'd0,     16'sd0,    16'sd0,    1'b0, 1'b0, 18'sd0,     18'sd0},
    '{1'b0, 16'd0,     16'sd0,    16'sd0,    1'b0, 1'b1, 18'sd0,     18'sd0},
    '{1'b0, 16'd0,     16'sd100,  -16'sd100, 1'b0, 1'b0, 18'sd0,     18'sd0},
    '{1'b0, 16'd0,     -16'sd32768, 16'sd32767, 1'b0, 1'b0, 18'sd0,  18'sd0},
    '{1'b0, 16'd0,     16'sd32767, -16'sd32768, 1'b0, 1'b0, 18'sd0,  18'sd0},
    // Zero tension: the segment is a straight line, so b3 equals k2.
    '{1'b1, 16'd0,     16'sd10,   16'sd20,   1'b1, 1'b0, 18'sd0,     18'sd0},
    '{1'b0, 16'd0,     -16'sd32768, 16'sd32767, 1'b0, 1'b0, 18'sd0,  18'sd0},
    '{1'b0, 16'd0,     16'sd32767, -16'sd32768, 1'b0, 1'b0, 18'sd0,  18'sd0},
    '{1'b0, 16'd0,     16'sd5,    16'sd6,    1'b0, 1'b1, 18'sd32767, -18'sd32768},
    '{1'b0, 16'd0,     16'sd1,    16'sd1,    1'b0, 1'b1, 18'sd5,     18'sd6},
    // Largest tension: b2 saturates on a single step at the end of the window.
    '{1'b1, 16'd65535, 16'sd0,    16'sd0,    1'b1, 1'b0, 18'sd0,     18'sd0},
    '{1'b0, 16'd0,     16'sd0,    16'sd0,    1'b0, 1'b0, 18'sd0,     18'sd0},
    '{1'b0, 16'd0,     16'sd0,    16'sd0,    1'b0, 1'b0, 18'sd0,     18'sd0},
    '{1'b0, 16'd0,     16'sd32767, -16'sd32768, 1'b0, 1'b1, 18'sd0,  18'sd0},
    '{1'b0, 16'd0,     -16'sd32768, 16'sd32767, 1'b0, 1'b0, 18'sd0,  18'sd0},
    // New curve on a full window, then again on a window holding one knot.
    '{1'b0, 16'd0,     16'sd7,    -16'sd7,   1'b1, 1'b0, 18'sd0,     18'sd0},
    '{1'b0, 16'd0,     -16'sd1,   16'sd1,    1'b1, 1'b0, 18'sd0,     18'sd0},
    '{1'b0, 16'd0,     16'sd1,    -16'sd1,   1'b0, 1'b0, 18'sd0,     18'sd0},
    '{1'b0, 16'd0,     -16'sd32768, -16'sd32768, 1'b0, 1'b0, 18'sd0, 18'sd0},
    '{1'b0, 16'd0,     16'sd32767, 16'sd32767, 1'b0, 1'b0, 18'sd0,   18'sd0},
    '{1'b0, 16'd0,     -16'sd2,   16'sd3,    1'b0, 1'b0, 18'sd0,     18'sd0}
  };

  cardinal_spline_to_bezier dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .knot_x(knot_x), .knot_y(knot_y), .start_curve(start_curve),
    .out_valid(out_valid), .out_stall(out_stall),
    .point_x(point_x), .point_y(point_y), .last_of_run(last_of_run),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #10 clk = ~clk;

  // Divide a Q12 sum by 4096, rounding halves away from zero.
  function automatic longint q12_round(input longint s);
    if (s >= 0) begin
      return (s + HALF_Q12) / ONE_Q12;
    end
    return -((-s + HALF_Q12) / ONE_Q12);
  endfunction

  function automatic longint third_round(input longint s);
    if (s >= 0) begin
      return (s + 1) / 3;
    end
    return -((-s + 1) / 3);
  endfunction

  function automatic logic signed [OW-1:0] clamp_point(input longint v);
    if (v > PT_MAX) begin
      v = PT_MAX;
    end else if (v < PT_MIN) begin
      v = PT_MIN;
    end
    return OW'(v);
  endfunction

  // Bezier control point idx of one coordinate for the window a0..a3.
  function automatic longint bezier_coord(input longint t, input longint a0, input longint a1,
                                          input longint a2, input longint a3, input int idx);
    longint c3, c2, c1, p1, p2;
    c3 = q12_round(-t * a0 + (TWO_Q12 - t) * a1 + (t - TWO_Q12) * a2 + t * a3);
    c2 = q12_round(2 * t * a0 + (t - THREE_Q12) * a1 + (THREE_Q12 - 2 * t) * a2 - t * a3);
    c1 = q12_round(-t * a0 + t * a2);
    p1 = a1 + third_round(c1);
    p2 = p1 + third_round(c1 + c2);
    case (idx)
      0:       return a1;
      1:       return p1;
      2:       return p2;
      default: return a1 + c1 + c2 + c3;
    endcase
  endfunction

  // Update the window with an accepted knot and queue the points it yields.
  task automatic convert_knot(input logic signed [KW-1:0] kx, input logic signed [KW-1:0] ky,
                              input logic sc);
    longint t;
    bez_point_t pt;
    t = longint'(cur_tension);
    if (sc) begin
      for (int i = 0; i < WIN_DEPTH; i++) begin
        win_x[i] = '0;
        win_y[i] = '0;
      end
      fill = 0;
      first_pending = 1'b1;
    end
    if (fill < WIN_FULL) begin
      win_x[fill] = kx;
      win_y[fill] = ky;
      fill++;
      return;
    end
    for (int i = (first_pending ? 0 : 1); i < 4; i++) begin
      pt.x = clamp_point(bezier_coord(t, win_x[0], win_x[1], win_x[2], kx, i));
      pt.y = clamp_point(bezier_coord(t, win_y[0], win_y[1], win_y[2], ky, i));
      pt.run_end = (i == 3);
      bezier_points_due.push_back(pt);
    end
    first_pending = 1'b0;
    win_x[0] = win_x[1];
    win_x[1] = win_x[2];
    win_x[2] = kx;
    win_y[0] = win_y[1];
    win_y[1] = win_y[2];
    win_y[2] = ky;
  endtask

  // Idle length: mostly none or short, now and then long.
  function automatic int idle_len();
    int r;
    if (no_idle) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 88) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  // Coordinates lean toward the extremes and small values.
  function automatic logic signed [KW-1:0] rand_coord();
    case ($urandom_range(0, 9))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2, 3, 4: return KW'(int'($urandom_range(0, 400)) - 200);
      default: return KW'($urandom);
    endcase
  endfunction

  function automatic logic [TW-1:0] phase_tension(input int ph);
    case (ph)
      0:       return 16'd2048;
      1:       return 16'd65535;
      2:       return 16'd0;
      3:       return 16'd4096;
      4:       return 16'd1;
      5:       return 16'd65534;
      6:       return TW'($urandom);
      default: return TENSION_RESET;
    endcase
  endfunction

  // Offer one knot and wait for the transaction.
  task automatic offer_knot(input logic signed [KW-1:0] kx, input logic signed [KW-1:0] ky,
                            input logic sc);
    in_valid <= 1'b1;
    knot_x <= kx;
    knot_y <= ky;
    start_curve <= sc;
    do @(posedge clk); while (in_stall);
    convert_knot(kx, ky, sc);
  endtask

  // Idle the input for a random gap.
  task automatic idle_gap();
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Offer one knot, wait for the transaction, then idle for a random gap.
  task automatic send_knot(input logic signed [KW-1:0] kx, input logic signed [KW-1:0] ky,
                           input logic sc);
    offer_knot(kx, ky, sc);
    idle_gap();
  endtask

  // Stop sending and let every queued point drain, plus the pipeline latency.
  task automatic settle();
    in_valid <= 1'b0;
    while (bezier_points_due.size() != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  // APB write of the tension register, followed by a read back.
  task automatic write_tension(input logic [TW-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= TENSION_ADDR;
    pwdata <= DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    cur_tension = value;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[TW-1:0] !== value) begin
      $error("tension: expected %0d, got %0d", value, prdata[TW-1:0]);
      error_count++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Output side: check each point transaction and stall at random.
  always @(posedge clk) begin
    bez_point_t due;
    if (!rst && out_valid && !out_stall) begin
      if (bezier_points_due.size() == 0) begin
        $error("point (%0d, %0d) with no point expected", point_x, point_y);
        error_count++;
      end else begin
        due = bezier_points_due.pop_front();
        if (point_x !== due.x) begin
          $error("point_x: expected %0d, got %0d", due.x, point_x);
          error_count++;
        end
        if (point_y !== due.y) begin
          $error("point_y: expected %0d, got %0d", due.y, point_y);
          error_count++;
        end
        if (last_of_run !== due.run_end) begin
          $error("last_of_run: expected %0d, got %0d", due.run_end, last_of_run);
          error_count++;
        end
      end
    end
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
      stall_left = idle_len();
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int len;
    int sent;
    bit broken;
    knot_row_t row;
    for (int i = 0; i < WIN_DEPTH; i++) begin
      win_x[i] = '0;
      win_y[i] = '0;
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed knots; typed rows pin the final point of their run before any gap,
    // so the pinned entry is still the newest one in the queue.
    for (int i = 0; i < NUM_DIRECTED; i++) begin
      row = directed_rows[i];
      if (row.cfg) begin
        settle();
        write_tension(row.tension);
      end
      offer_knot(row.x, row.y, row.sc);
      if (row.typed) begin
        bezier_points_due[bezier_points_due.size() - 1] = '{row.ex, row.ey, 1'b1};
      end
      idle_gap();
    end

    // Random curves, one tension setting per phase.
    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      write_tension(phase_tension(ph));
      no_idle = (ph == 2 || ph == 5);
      sent = 0;
      while (sent < PHASE_KNOTS) begin
        broken = ($urandom_range(0, 9) >= 8);
        len = broken ? $urandom_range(1, 3) : $urandom_range(4, 16);
        for (int k = 0; k < len && sent < PHASE_KNOTS; k++) begin
          send_knot(rand_coord(), rand_coord(),
                    (k == 0) || (broken && $urandom_range(0, 1) == 1));
          sent++;
          // Hold the sender until the output side has caught up completely.
          if (ph == 3 && sent == PHASE_KNOTS / 2) begin
            settle();
          end
        end
      end
    end

    no_idle = 1'b0;
    settle();
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
